FILE: rtl/core/u8san_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8san_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ASCII_MAX    = 8'h7F;
   localparam logic [7:0] LEAD2_MIN    = 8'hC2;
   localparam logic [7:0] LEAD2_MAX    = 8'hDF;
   localparam logic [7:0] LEAD3_E0     = 8'hE0;
   localparam logic [7:0] LEAD3_ED     = 8'hED;
   localparam logic [7:0] LEAD4_F0     = 8'hF0;
   localparam logic [7:0] LEAD4_F4     = 8'hF4;
   localparam logic [7:0] CONT_MIN     = 8'h80;
   localparam logic [7:0] CONT_MAX     = 8'hBF;
   localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
   localparam logic [7:0] ED_CONT_MAX  = 8'h9F;
   localparam logic [7:0] F0_CONT_MIN  = 8'h90;
   localparam logic [7:0] F4_CONT_MAX  = 8'h8F;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   localparam logic [7:0] REPL_BYTE0   = 8'hEF;
   localparam logic [7:0] REPL_BYTE1   = 8'hBF;
   localparam logic [7:0] REPL_BYTE2   = 8'hBD;

   localparam logic [1:0] JUDGE_VALID      = 2'd0;
   localparam logic [1:0] JUDGE_INCOMPLETE = 2'd1;
   localparam logic [1:0] JUDGE_INVALID    = 2'd2;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] len;
   } judge_type;

   // One queued item of work: up to four output bytes, first byte in tok_data[0].
   typedef struct packed {
      logic [3:0][7:0] tok_data;
      logic [1:0]      len_m1;
      logic            last;
   } token_type;

   function automatic judge_type judge(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic [2:0] avail);
      judge_type  res;
      logic [2:0] need;
      logic [7:0] lo;
      logic [7:0] hi;
      logic       bad_lead;
      lo       = CONT_MIN;
      hi       = CONT_MAX;
      need     = 3'd1;
      bad_lead = 1'b0;
      if (b0 <= ASCII_MAX) begin
         need = 3'd1;
      end else if (b0 inside {[LEAD2_MIN:LEAD2_MAX]}) begin
         need = 3'd2;
      end else if (b0 == LEAD3_E0) begin
         need = 3'd3;
         lo   = E0_CONT_MIN;
      end else if (b0 == LEAD3_ED) begin
         need = 3'd3;
         hi   = ED_CONT_MAX;
      end else if (b0 inside {[8'hE1:8'hEF]}) begin
         need = 3'd3;
      end else if (b0 == LEAD4_F0) begin
         need = 3'd4;
         lo   = F0_CONT_MIN;
      end else if (b0 == LEAD4_F4) begin
         need = 3'd4;
         hi   = F4_CONT_MAX;
      end else if (b0 inside {[8'hF1:8'hF3]}) begin
         need = 3'd4;
      end else begin
         bad_lead = 1'b1;
      end
      res.len = need;
      if (bad_lead) begin
         res.status = JUDGE_INVALID;
      end else if (need == 3'd1) begin
         res.status = JUDGE_VALID;
      end else if (avail < need) begin
         res.status = JUDGE_INCOMPLETE;
      end else if (b1 < lo || b1 > hi) begin
         res.status = JUDGE_INVALID;
      end else if (need >= 3'd3 && b2[7:6] != CONT_TAG) begin
         res.status = JUDGE_INVALID;
      end else if (need == 3'd4 && b3[7:6] != CONT_TAG) begin
         res.status = JUDGE_INVALID;
      end else begin
         res.status = JUDGE_VALID;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/u8san_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic                 req_action,
   input  wire logic [7:0]           req_data_byte,
   output logic                      req_full,
   input  wire logic                 q_full,
   output logic                      q_push,
   output u8san_pkg::token_type      q_token
);
   import u8san_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic            state_ff, state_in;
   logic [2:0]      pos_ff, pos_in;
   logic [2:0]      total_ff, total_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [3:0][7:0] buf_ff, buf_in;

   logic [3:0][7:0] win0, win1;
   judge_type       j0, j1;
   logic [2:0]      step, pos_next;
   logic            terminal;
   logic            fin;
   logic [2:0]      fin_pos;
   logic            accept;

   assign req_full = (state_ff == ST_SCAN) || q_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         win0[k] = buf_ff[pos_ff[1:0] + 2'(k)];
      end
      j0       = judge(win0[0], win0[1], win0[2], win0[3], 3'(total_ff - pos_ff));
      step     = (j0.status == JUDGE_VALID) ? j0.len : 3'd1;
      pos_next = 3'(pos_ff + step);
      for (int k = 0; k < 4; k++) begin
         win1[k] = buf_ff[pos_next[1:0] + 2'(k)];
      end
      j1       = judge(win1[0], win1[1], win1[2], win1[3], 3'(total_ff - pos_next));
      terminal = (pos_next == total_ff) || (j1.status == JUDGE_INCOMPLETE);
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      held_count_in = held_count_ff;
      held_in       = held_ff;
      buf_in        = buf_ff;
      q_push        = 1'b0;
      q_token       = '0;
      fin           = 1'b0;
      fin_pos       = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action) begin
                  if (held_count_ff != 2'd0) begin
                     q_push              = 1'b1;
                     q_token.tok_data[0] = REPL_BYTE0;
                     q_token.tok_data[1] = REPL_BYTE1;
                     q_token.tok_data[2] = REPL_BYTE2;
                     q_token.len_m1      = 2'd2;
                     q_token.last        = 1'b1;
                  end
                  held_count_in = 2'd0;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     if (2'(k) < held_count_ff) begin
                        buf_in[k] = held_ff[k];
                     end else begin
                        buf_in[k] = req_data_byte;
                     end
                  end
                  buf_in[3] = req_data_byte;
                  total_in = 3'({1'b0, held_count_ff} + 3'd1);
                  pos_in   = 3'd0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (j0.status == JUDGE_INCOMPLETE) begin
               fin     = 1'b1;
               fin_pos = pos_ff;
            end else if (!q_full) begin
               q_push = 1'b1;
               if (j0.status == JUDGE_VALID) begin
                  q_token.tok_data = win0;
                  q_token.len_m1   = 2'(j0.len - 3'd1);
               end else begin
                  q_token.tok_data[0] = REPL_BYTE0;
                  q_token.tok_data[1] = REPL_BYTE1;
                  q_token.tok_data[2] = REPL_BYTE2;
                  q_token.len_m1      = 2'd2;
               end
               q_token.last = terminal;
               if (terminal) begin
                  fin     = 1'b1;
                  fin_pos = pos_next;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (fin) begin
         for (int k = 0; k < 3; k++) begin
            held_in[k] = buf_ff[fin_pos[1:0] + 2'(k)];
         end
         held_count_in = 2'(total_ff - fin_pos);
         state_in      = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= 2'd0;
         pos_ff        <= 3'd0;
         total_ff      <= 3'd0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      buf_ff  <= buf_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/u8san_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u8san_pkg::token_type push_token,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output u8san_pkg::token_type      head
);
   import u8san_pkg::*;

   token_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/u8san_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire u8san_pkg::token_type q_head,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last
);
   import u8san_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   token_type  cur_ff, cur_in;
   logic       pop_fire, done;

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = cur_ff.tok_data[idx_ff];
   assign rsp_last     = cur_ff.last && (idx_ff == cur_ff.len_m1);
   assign pop_fire     = rsp_pop && valid_ff;
   assign done         = pop_fire && (idx_ff == cur_ff.len_m1);
   assign q_pop        = (!valid_ff || done) && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         cur_in   = q_head;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (pop_fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_stream_sanitizer_unit.sv
// UTF-8 stream sanitizer. Bytes enter one item at a time and only well-formed UTF-8
// leaves, one byte per result item; each bad sequence is replaced by EF BF BD, and a
// flush item turns any held partial sequence into one replacement. The last byte that
// an input item produces is marked by rsp_last. A data item is taken and then scanned
// at one judged sequence per cycle while the queue has room; a flush item needs no
// scan. Results leave the output serializer at one byte per cycle while the receiver
// pops, and one input item can produce up to twelve bytes. A four-entry queue between
// scanner and serializer lets the two sides stall independently.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_sanitizer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic       req_action,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);
   import u8san_pkg::*;

   logic      q_full, q_push, q_empty, q_pop;
   token_type q_token, q_head;

   u8san_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_token       (q_token)
   );

   u8san_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   u8san_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

FILE: test/tb_utf8_stream_sanitizer_unit.sv
`timescale 1ns / 1ps

typedef enum logic {
   ACT_DATA  = 1'b0,
   ACT_FLUSH = 1'b1
} stream_action_type;

class utf8_scoreboard;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } sanitized_byte_type;

   sanitized_byte_type expected_q[$];
   logic [7:0]         held_val[3];
   int                 held_cnt;
   int                 errors;

   function new();
      for (int k = 0; k < 3; k++) begin
         held_val[k] = 8'h00;
      end
      held_cnt = 0;
      errors   = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void expect_byte(logic [7:0] value);
      sanitized_byte_type item;
      item.value = value;
      item.last  = 1'b0;
      expected_q = {expected_q, item};
   endfunction

   function void expect_replacement();
      expect_byte(u8san_pkg::REPL_BYTE0);
      expect_byte(u8san_pkg::REPL_BYTE1);
      expect_byte(u8san_pkg::REPL_BYTE2);
   endfunction

   // Classifies the sequence that starts at b0, given how many bytes are on hand.
   function logic [1:0] scan_status(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3, int avail, output int need);
      logic [7:0] lo;
      logic [7:0] hi;
      lo   = u8san_pkg::CONT_MIN;
      hi   = u8san_pkg::CONT_MAX;
      need = 1;
      if (b0 <= u8san_pkg::ASCII_MAX) begin
         return u8san_pkg::JUDGE_VALID;
      end else if (b0 >= u8san_pkg::LEAD2_MIN && b0 <= u8san_pkg::LEAD2_MAX) begin
         need = 2;
      end else if (b0 == u8san_pkg::LEAD3_E0) begin
         need = 3;
         lo   = u8san_pkg::E0_CONT_MIN;
      end else if (b0 == u8san_pkg::LEAD3_ED) begin
         need = 3;
         hi   = u8san_pkg::ED_CONT_MAX;
      end else if (b0 > u8san_pkg::LEAD3_E0 && b0 < u8san_pkg::LEAD4_F0) begin
         need = 3;
      end else if (b0 == u8san_pkg::LEAD4_F0) begin
         need = 4;
         lo   = u8san_pkg::F0_CONT_MIN;
      end else if (b0 == u8san_pkg::LEAD4_F4) begin
         need = 4;
         hi   = u8san_pkg::F4_CONT_MAX;
      end else if (b0 > u8san_pkg::LEAD4_F0 && b0 < u8san_pkg::LEAD4_F4) begin
         need = 4;
      end else begin
         return u8san_pkg::JUDGE_INVALID;
      end
      if (avail < need) begin
         return u8san_pkg::JUDGE_INCOMPLETE;
      end
      if (b1 < lo || b1 > hi) begin
         return u8san_pkg::JUDGE_INVALID;
      end
      if (need >= 3 && b2[7:6] != u8san_pkg::CONT_TAG) begin
         return u8san_pkg::JUDGE_INVALID;
      end
      if (need == 4 && b3[7:6] != u8san_pkg::CONT_TAG) begin
         return u8san_pkg::JUDGE_INVALID;
      end
      return u8san_pkg::JUDGE_VALID;
   endfunction

   function void note_input(stream_action_type action, logic [7:0] data);
      logic [7:0] scan_b[7];
      logic [1:0] status;
      int         total;
      int         pos;
      int         need;
      int         start_size;
      start_size = expected_q.size();
      for (int k = 0; k < 7; k++) begin
         scan_b[k] = 8'h00;
      end
      if (action == ACT_FLUSH) begin
         if (held_cnt != 0) begin
            expect_replacement();
         end
         held_cnt = 0;
      end else begin
         for (int k = 0; k < held_cnt; k++) begin
            scan_b[k] = held_val[k];
         end
         scan_b[held_cnt] = data;
         total = held_cnt + 1;
         pos   = 0;
         while (pos < total) begin
            status = scan_status(scan_b[pos], scan_b[pos + 1], scan_b[pos + 2],
                                 scan_b[pos + 3], total - pos, need);
            if (status == u8san_pkg::JUDGE_VALID) begin
               for (int k = 0; k < need; k++) begin
                  expect_byte(scan_b[pos + k]);
               end
               pos += need;
            end else if (status == u8san_pkg::JUDGE_INCOMPLETE) begin
               break;
            end else begin
               expect_replacement();
               pos++;
            end
         end
         held_cnt = total - pos;
         for (int k = 0; k < held_cnt; k++) begin
            held_val[k] = scan_b[pos + k];
         end
      end
      if (expected_q.size() > start_size) begin
         expected_q[expected_q.size() - 1].last = 1'b1;
      end
   endfunction

   function void check_result(logic [7:0] out_byte, logic last);
      sanitized_byte_type exp_item;
      if (expected_q.size() == 0) begin
         $error("unexpected item: rsp_out_byte %02h, rsp_last %0b", out_byte, last);
         errors++;
         return;
      end
      exp_item = expected_q.pop_front();
      if (out_byte !== exp_item.value) begin
         $error("rsp_out_byte: expected %02h, actual %02h", exp_item.value, out_byte);
         errors++;
      end
      if (last !== exp_item.last) begin
         $error("rsp_last: expected %0b, actual %0b", exp_item.last, last);
         errors++;
      end
   endfunction

endclass

module tb_utf8_stream_sanitizer_unit;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 30;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic       req_action;
   logic [7:0] req_data_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   utf8_scoreboard sb;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             rsp_hold_cycles;
   int             items_sent;
   int             cycle_count;

   logic [7:0] directed_bytes[22] = '{
      8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFF, 8'hC2, 8'h80,
      8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80,
      8'hF4, 8'h90, 8'h80, 8'h80, 8'hE1, 8'h41, 8'h42, 8'hF0, 8'h90
   };

   utf8_stream_sanitizer_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_input(stream_action_type'(req_action), req_data_byte);
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_result(rsp_out_byte, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[utf8_stream_sanitizer_unit] ERROR");
         $finish;
      end
   end

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input stream_action_type action, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_action    <= action;
      req_data_byte <= data;
      do begin
         @(posedge clock);
      end while (req_full);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Sends one UTF-8 sequence, optionally cut short or with one byte spoiled.
   task automatic send_utf8(input bit truncate, input bit corrupt);
      logic [7:0] seq_b[4];
      logic [7:0] bad_second;
      int         len;
      int         keep;
      int         j;
      for (int k = 0; k < 4; k++) begin
         seq_b[k] = 8'($urandom_range(8'hBF, 8'h80));
      end
      bad_second = 8'($urandom_range(8'h7F));
      case ($urandom_range(3))
         0: begin
            len      = 1;
            seq_b[0] = 8'($urandom_range(8'h7F));
         end
         1: begin
            len      = 2;
            seq_b[0] = 8'($urandom_range(8'hDF, 8'hC2));
         end
         2: begin
            len = 3;
            case ($urandom_range(3))
               0: begin
                  seq_b[0]   = u8san_pkg::LEAD3_E0;
                  seq_b[1]   = 8'($urandom_range(8'hBF, 8'hA0));
                  bad_second = 8'($urandom_range(8'h9F, 8'h80));
               end
               1: begin
                  seq_b[0]   = u8san_pkg::LEAD3_ED;
                  seq_b[1]   = 8'($urandom_range(8'h9F, 8'h80));
                  bad_second = 8'($urandom_range(8'hBF, 8'hA0));
               end
               default: begin
                  seq_b[0] = 8'($urandom_range(8'hEF, 8'hE1));
                  if (seq_b[0] == u8san_pkg::LEAD3_ED) begin
                     seq_b[0] = 8'hEE;
                  end
               end
            endcase
         end
         default: begin
            len = 4;
            case ($urandom_range(3))
               0: begin
                  seq_b[0]   = u8san_pkg::LEAD4_F0;
                  seq_b[1]   = 8'($urandom_range(8'hBF, 8'h90));
                  bad_second = 8'($urandom_range(8'h8F, 8'h80));
               end
               1: begin
                  seq_b[0]   = u8san_pkg::LEAD4_F4;
                  seq_b[1]   = 8'($urandom_range(8'h8F, 8'h80));
                  bad_second = 8'($urandom_range(8'hBF, 8'h90));
               end
               default: begin
                  seq_b[0] = 8'($urandom_range(8'hF3, 8'hF1));
               end
            endcase
         end
      endcase
      if (corrupt && len > 1) begin
         j = $urandom_range(len - 1, 1);
         if (j == 1 && $urandom_range(1) == 1) begin
            seq_b[1] = bad_second;
         end else if ($urandom_range(1) == 1) begin
            seq_b[j] = 8'($urandom_range(8'h7F));
         end else begin
            seq_b[j] = 8'($urandom_range(8'hFF, 8'hC0));
         end
      end
      keep = (truncate && len > 1) ? $urandom_range(len - 1, 1) : len;
      for (int k = 0; k < keep; k++) begin
         send_item(ACT_DATA, seq_b[k]);
      end
   endtask

   task automatic send_random_traffic(input int count);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_utf8(1'b0, 1'b0);
         end else if (pick < 70) begin
            send_utf8(1'b1, 1'b0);
         end else if (pick < 80) begin
            send_utf8(1'b0, 1'b1);
         end else if (pick < 88) begin
            send_item(ACT_DATA, 8'($urandom_range(255)));
         end else if (pick < 94) begin
            if ($urandom_range(1) == 1) begin
               send_item(ACT_DATA, 8'($urandom_range(8'hC1, 8'h80)));
            end else begin
               send_item(ACT_DATA, 8'($urandom_range(8'hFF, 8'hF5)));
            end
         end else begin
            send_item(ACT_FLUSH, 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_push        = 1'b0;
      req_action      = ACT_DATA;
      req_data_byte   = 8'h00;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 0;
      items_sent      = 0;
      cycle_count     = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // A flush with nothing held must produce no item at all.
      send_item(ACT_FLUSH, 8'hFF);
      foreach (directed_bytes[k]) begin
         send_item(ACT_DATA, directed_bytes[k]);
      end
      send_item(ACT_FLUSH, 8'h00);
      wait_drained();

      send_random_traffic(45);
      wait_drained();

      // The receiver holds off while the sender keeps offering items.
      rsp_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < 20; k++) begin
         send_utf8(1'b0, 1'b0);
      end
      wait_drained();

      send_idle_pct = 87;
      send_random_traffic(45);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 87;
      send_random_traffic(45);
      wait_drained();

      send_idle_pct  = 34;
      recv_stall_pct = 34;
      send_random_traffic(45);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[utf8_stream_sanitizer_unit] OK");
      end else begin
         $display("[utf8_stream_sanitizer_unit] ERROR");
      end
      $finish;
   end

endmodule
